>>> design/nta_pkg.sv
// shared types, constants and helpers of the neighbor table
package nta_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int PCNT_W      = 5;
    localparam int CFG_IDX_W   = 3;

    localparam logic [31:0] TIMEOUT_RESET = 32'd22000;
    localparam logic [31:0] REVERSE_RESET = 32'd5200;

    localparam logic [1:0] MODE_DISC  = 2'd0;
    localparam logic [1:0] MODE_DATA  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_HIGH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_LOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REV_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_UP     = 3'd4;

    typedef enum logic [3:0] {
        EV_IGNORED   = 4'd0,
        EV_OWN       = 4'd1,
        EV_BADLEN    = 4'd2,
        EV_BADTOK    = 4'd3,
        EV_REFRESH   = 4'd4,
        EV_ADDED     = 4'd5,
        EV_FULL      = 4'd6,
        EV_DATA_OK   = 4'd7,
        EV_DATA_DROP = 4'd8,
        EV_REVERSE   = 4'd9,
        EV_DONE      = 4'd10
    } event_t;

    typedef struct packed {
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [31:0] heard;
        logic [31:0] rev;
    } entry_t;

    // write command broadcast to the cell row
    typedef struct packed {
        logic   load_all;
        logic   load_heard;
        logic   mark;
        entry_t data;
    } cell_cmd_t;

    // status reported by one cell
    typedef struct packed {
        entry_t data;
        logic   send;
        logic   expired;
        logic   first;
    } cell_stat_t;

    typedef struct packed {
        logic [63:0] own_hi;
        logic [63:0] own_lo;
        logic [31:0] timeout;
        logic [31:0] interval;
        logic        link_up;
    } cfg_t;

    function automatic logic [PCNT_W-1:0] to_pcount(input logic [CNT_W-1:0] c);
        logic [CNT_W+PCNT_W-1:0] w;
        w = {{PCNT_W{1'b0}}, c};
        return w[PCNT_W-1:0];
    endfunction

endpackage

>>> design/nta_in_if.sv
// input item channel
interface nta_in_if import nta_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic        length_ok;
    logic        token_match;
    logic [31:0] now_tick;

    modport source (output valid, mode, addr_high, addr_low, length_ok, token_match,
                    now_tick, input ready);
    modport sink (input valid, mode, addr_high, addr_low, length_ok, token_match,
                  now_tick, output ready);
endinterface

>>> design/nta_out_if.sv
// result channel
interface nta_out_if import nta_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [3:0]        event_res;
    logic [63:0]       peer_addr_high;
    logic [63:0]       peer_addr_low;
    logic [PCNT_W-1:0] peer_count;
    logic              last;

    modport source (output valid, event_res, peer_addr_high, peer_addr_low, peer_count,
                    last, input ready);
    modport sink (input valid, event_res, peer_addr_high, peer_addr_low, peer_count,
                  last, output ready);
endinterface

>>> design/nta_cfg_if.sv
// configuration write channel
interface nta_cfg_if import nta_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> design/nta_cfg.sv
// configuration register bank
module nta_cfg import nta_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    nta_cfg_if.sink   cfg,
    output cfg_t      regs
);

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.own_hi   <= '0;
            regs_reg.own_lo   <= '0;
            regs_reg.timeout  <= TIMEOUT_RESET;
            regs_reg.interval <= REVERSE_RESET;
            regs_reg.link_up  <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_OWN_HIGH:     regs_reg.own_hi   <= cfg.data;
                CFG_OWN_LOW:      regs_reg.own_lo   <= cfg.data;
                CFG_TIMEOUT:      regs_reg.timeout  <= cfg.data[31:0];
                CFG_REV_INTERVAL: regs_reg.interval <= cfg.data[31:0];
                CFG_LINK_UP:      regs_reg.link_up  <= cfg.data[0];
                default:          ;
            endcase
        end
    end

endmodule

>>> design/nta_cell.sv
// one table entry with its own match and aging compare
module nta_cell import nta_pkg::*;
(
    input  logic        clk,
    input  logic        sel,
    input  cell_cmd_t   cmd,
    input  logic        live,
    input  logic [63:0] key_hi,
    input  logic [63:0] key_lo,
    input  logic [31:0] now,
    input  logic [31:0] timeout,
    input  logic [31:0] interval,
    input  logic        hit_in,
    output logic        hit_out,
    output cell_stat_t  stat
);

    entry_t      ent_reg;
    logic        send_reg;
    logic        match;
    logic        due;
    logic [31:0] heard_age;
    logic [31:0] rev_age;

    assign heard_age = now - ent_reg.heard;
    assign rev_age   = now - ent_reg.rev;
    assign due       = rev_age > interval;
    assign match     = live && (ent_reg.addr_hi == key_hi) && (ent_reg.addr_lo == key_lo);
    assign hit_out   = hit_in | match;

    assign stat.data    = ent_reg;
    assign stat.send    = send_reg;
    assign stat.expired = heard_age > timeout;
    assign stat.first   = match & ~hit_in;

    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            if (cmd.load_all)
            begin
                ent_reg <= cmd.data;
            end
            else if (cmd.load_heard)
            begin
                ent_reg.heard <= cmd.data.heard;
            end
            else if (cmd.mark)
            begin
                send_reg <= due;
                if (due)
                begin
                    ent_reg.rev <= now;
                end
            end
        end
    end

endmodule

>>> design/neighbor_table_with_aging.sv
// neighbor table top level: item control, cell row and result register
// discovery, data and clear items: the item is latched from S_IDLE, the result word is loaded
//   from S_LOOK once the output register is free, and input ready returns with that load
// tick items: S_LOOK, then S_SCAN walks the live slots (removing expired ones), then S_EMIT
//   sends a reverse word for each kept slot that is due, then S_DONE sends the done word
// reset empties the table (count to zero) and loads the config register defaults
module neighbor_table_with_aging import nta_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    nta_in_if.sink    in_ch,
    nta_out_if.source out_ch,
    nta_cfg_if.sink   cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_EMIT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;

    // latched item
    logic [1:0]  mode_reg;
    logic [63:0] hi_reg;
    logic [63:0] lo_reg;
    logic        len_reg;
    logic        tok_reg;
    logic [31:0] now_reg;

    // result register
    logic              out_valid_reg;
    event_t            out_ev_reg;
    logic [63:0]       out_hi_reg;
    logic [63:0]       out_lo_reg;
    logic [PCNT_W-1:0] out_cnt_reg;
    logic              out_last_reg;

    cfg_t regs;

    cell_cmd_t                  cmd;
    logic [TABLE_DEPTH-1:0]     sel;
    logic [TABLE_DEPTH-1:0]     live;
    logic [TABLE_DEPTH:0]       hit_chain;
    cell_stat_t                 stat [TABLE_DEPTH];
    cell_stat_t                 cur;
    cell_stat_t                 tail;
    logic                       any_hit;

    logic        out_free;
    logic        load;
    event_t      ld_ev;
    logic [63:0] ld_hi;
    logic [63:0] ld_lo;
    logic        ld_last;
    logic        in_fire;
    logic [CNT_W-1:0] tail_idx;

    nta_cfg u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // the cell row; the first-match flag ripples from cell to cell
    assign hit_chain[0] = 1'b0;

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        assign live[g] = CNT_W'(g) < cnt_reg;

        nta_cell u_cell
        (
            .clk      (clk),
            .sel      (sel[g]),
            .cmd      (cmd),
            .live     (live[g]),
            .key_hi   (hi_reg),
            .key_lo   (lo_reg),
            .now      (now_reg),
            .timeout  (regs.timeout),
            .interval (regs.interval),
            .hit_in   (hit_chain[g]),
            .hit_out  (hit_chain[g+1]),
            .stat     (stat[g])
        );
    end

    assign any_hit  = hit_chain[TABLE_DEPTH];
    assign tail_idx = cnt_reg - CNT_W'(1);

    // pick the slot under the walk index and the last occupied slot
    always_comb
    begin
        cur  = '0;
        tail = '0;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            if (CNT_W'(k) == idx_reg)
            begin
                cur = stat[k];
            end
            if (CNT_W'(k) == tail_idx)
            begin
                tail = stat[k];
            end
        end
    end

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid & in_ch.ready;
    assign out_free    = ~out_valid_reg | out_ch.ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        sel        = '0;
        load       = 1'b0;
        ld_ev      = EV_IGNORED;
        ld_hi      = hi_reg;
        ld_lo      = lo_reg;
        ld_last    = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_LOOK;
                end
            end

            S_LOOK:
            begin
                case (mode_reg)
                    MODE_TICK:
                    begin
                        idx_next   = '0;
                        state_next = S_SCAN;
                    end
                    MODE_CLEAR:
                    begin
                        if (out_free)
                        begin
                            cnt_next   = '0;
                            load       = 1'b1;
                            ld_hi      = '0;
                            ld_lo      = '0;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            load       = 1'b1;
                            state_next = S_IDLE;
                            if (!regs.link_up)
                            begin
                                ld_ev = EV_IGNORED;
                            end
                            else if (mode_reg == MODE_DISC)
                            begin
                                if (!len_reg)
                                begin
                                    ld_ev = EV_BADLEN;
                                end
                                else if (hi_reg == regs.own_hi && lo_reg == regs.own_lo)
                                begin
                                    ld_ev = EV_OWN;
                                end
                                else if (!tok_reg)
                                begin
                                    ld_ev = EV_BADTOK;
                                end
                                else if (any_hit)
                                begin
                                    ld_ev = EV_REFRESH;
                                    cmd.load_heard = 1'b1;
                                    cmd.data.heard = now_reg;
                                    for (int k = 0; k < TABLE_DEPTH; k++)
                                    begin
                                        sel[k] = stat[k].first;
                                    end
                                end
                                else if (cnt_reg == CNT_W'(TABLE_DEPTH))
                                begin
                                    ld_ev = EV_FULL;
                                end
                                else
                                begin
                                    // append at the end of the table
                                    ld_ev             = EV_ADDED;
                                    cmd.load_all      = 1'b1;
                                    cmd.data.addr_hi  = hi_reg;
                                    cmd.data.addr_lo  = lo_reg;
                                    cmd.data.heard    = now_reg;
                                    cmd.data.rev      = '0;
                                    cnt_next          = cnt_reg + CNT_W'(1);
                                    for (int k = 0; k < TABLE_DEPTH; k++)
                                    begin
                                        sel[k] = (CNT_W'(k) == cnt_reg);
                                    end
                                end
                            end
                            else if (any_hit)
                            begin
                                ld_ev          = EV_DATA_OK;
                                cmd.load_heard = 1'b1;
                                cmd.data.heard = now_reg;
                                for (int k = 0; k < TABLE_DEPTH; k++)
                                begin
                                    sel[k] = stat[k].first;
                                end
                            end
                            else
                            begin
                                ld_ev = EV_DATA_DROP;
                            end
                        end
                    end
                endcase
            end

            S_SCAN:
            begin
                if (idx_reg < cnt_reg)
                begin
                    for (int k = 0; k < TABLE_DEPTH; k++)
                    begin
                        sel[k] = (CNT_W'(k) == idx_reg);
                    end
                    if (cur.expired)
                    begin
                        // swap-remove: last entry moves in, same slot is checked again
                        cmd.load_all = 1'b1;
                        cmd.data     = tail.data;
                        cnt_next     = tail_idx;
                    end
                    else
                    begin
                        // note whether a reverse announce is due and, if so, restamp it
                        cmd.mark = 1'b1;
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                // walk the surviving slots and send a reverse word for each one flagged to send
                if (idx_reg < cnt_reg)
                begin
                    if (cur.send)
                    begin
                        if (out_free)
                        begin
                            load     = 1'b1;
                            ld_ev    = EV_REVERSE;
                            ld_hi    = cur.data.addr_hi;
                            ld_lo    = cur.data.addr_lo;
                            ld_last  = 1'b0;
                            idx_next = idx_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    ld_ev      = EV_DONE;
                    ld_hi      = '0;
                    ld_lo      = '0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_ev_reg    <= EV_IGNORED;
            out_hi_reg    <= '0;
            out_lo_reg    <= '0;
            out_cnt_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
                out_ev_reg    <= ld_ev;
                out_hi_reg    <= ld_hi;
                out_lo_reg    <= ld_lo;
                out_cnt_reg   <= to_pcount(cnt_next);
                out_last_reg  <= ld_last;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // latched input word
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg <= in_ch.mode;
            hi_reg   <= in_ch.addr_high;
            lo_reg   <= in_ch.addr_low;
            len_reg  <= in_ch.length_ok;
            tok_reg  <= in_ch.token_match;
            now_reg  <= in_ch.now_tick;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.event_res      = out_ev_reg;
    assign out_ch.peer_addr_high = out_hi_reg;
    assign out_ch.peer_addr_low  = out_lo_reg;
    assign out_ch.peer_count     = out_cnt_reg;
    assign out_ch.last           = out_last_reg;

    // table never grows past its depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // the scan index never runs past the live entries
    a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (idx_reg <= cnt_reg))
        else $error("scan index past entry count");

    // a scan step removes at most one peer
    a_scan_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |=> (cnt_reg == $past(cnt_reg) ||
                                   cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("scan removed more than one peer");

    // reverse words are never flagged as the end of a tick
    a_rev_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ev_reg == EV_REVERSE) |-> !out_last_reg)
        else $error("reverse announce marked last");

endmodule

>>> tb/neighbor_table_with_aging_tb.sv
// self-checking testbench of the neighbor table with aging
`timescale 1ns / 100ps

module neighbor_table_with_aging_tb;
    import nta_pkg::*;

    localparam int STALL_LIMIT = 5000;  // cycles with no word moved on any channel
    localparam int DRAIN_WAIT  = 3 * TABLE_DEPTH + 16;

    typedef struct packed {
        event_t      ev;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [4:0]  cnt;
        logic        fin;
    } peer_word_t;

    logic clk;
    logic rst_n;

    nta_in_if  in_ch ();
    nta_out_if out_ch ();
    nta_cfg_if cfg ();

    neighbor_table_with_aging i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // shadow of the table and the registers
    logic [63:0] sh_own_hi, sh_own_lo;
    logic [31:0] sh_timeout, sh_interval;
    logic        sh_link;
    logic [63:0] tbl_hi [TABLE_DEPTH];
    logic [63:0] tbl_lo [TABLE_DEPTH];
    logic [31:0] tbl_heard [TABLE_DEPTH];
    logic [31:0] tbl_rev [TABLE_DEPTH];
    int          tbl_count;

    peer_word_t  pending_q [$];
    int          mismatches;
    int          quiet_cycles;
    bit          no_gaps;       // sender runs back to back while set

    // stimulus helpers
    logic [63:0] pool_hi [24];
    logic [63:0] pool_lo [24];
    logic [31:0] clock_now;

    always #6 clk = ~clk;

    // expected results of one accepted word, pushed in order
    function automatic void push_word(event_t ev, logic [63:0] hi, logic [63:0] lo, bit fin);
        peer_word_t w;
        w.ev  = ev;
        w.hi  = hi;
        w.lo  = lo;
        w.cnt = 5'd0;
        w.fin = fin;
        pending_q.push_back(w);
    endfunction

    function automatic void predict_table(logic [1:0] mode, logic [63:0] hi, logic [63:0] lo,
                                          logic lok, logic tok, logic [31:0] now);
        int     first_new;
        int     hit;
        int     i;
        event_t ev;
        first_new = pending_q.size();
        hit = -1;
        if (mode == MODE_DISC || mode == MODE_DATA)
        begin
            for (i = 0; i < tbl_count; i++)
                if (hit < 0 && tbl_hi[i] == hi && tbl_lo[i] == lo)
                    hit = i;
            if (!sh_link)
                ev = EV_IGNORED;
            else if (mode == MODE_DISC)
            begin
                if (!lok)
                    ev = EV_BADLEN;
                else if (hi == sh_own_hi && lo == sh_own_lo)
                    ev = EV_OWN;
                else if (!tok)
                    ev = EV_BADTOK;
                else if (hit >= 0)
                begin
                    tbl_heard[hit] = now;
                    ev = EV_REFRESH;
                end
                else if (tbl_count >= TABLE_DEPTH)
                    ev = EV_FULL;
                else
                begin
                    tbl_hi[tbl_count]    = hi;
                    tbl_lo[tbl_count]    = lo;
                    tbl_heard[tbl_count] = now;
                    tbl_rev[tbl_count]   = 32'd0;
                    tbl_count++;
                    ev = EV_ADDED;
                end
            end
            else if (hit >= 0)
            begin
                tbl_heard[hit] = now;
                ev = EV_DATA_OK;
            end
            else
                ev = EV_DATA_DROP;
            push_word(ev, hi, lo, 1'b1);
        end
        else if (mode == MODE_TICK)
        begin
            i = 0;
            while (i < tbl_count)
            begin
                if (32'(now - tbl_heard[i]) > sh_timeout)
                begin
                    // swap-remove, the moved entry is checked in the same slot
                    tbl_hi[i]    = tbl_hi[tbl_count-1];
                    tbl_lo[i]    = tbl_lo[tbl_count-1];
                    tbl_heard[i] = tbl_heard[tbl_count-1];
                    tbl_rev[i]   = tbl_rev[tbl_count-1];
                    tbl_count--;
                end
                else
                begin
                    if (32'(now - tbl_rev[i]) > sh_interval)
                    begin
                        push_word(EV_REVERSE, tbl_hi[i], tbl_lo[i], 1'b0);
                        tbl_rev[i] = now;
                    end
                    i++;
                end
            end
            push_word(EV_DONE, 64'd0, 64'd0, 1'b1);
        end
        else
        begin
            tbl_count = 0;
            push_word(EV_IGNORED, 64'd0, 64'd0, 1'b1);
        end
        // count is the one after the whole step
        for (i = first_new; i < pending_q.size(); i++)
            pending_q[i].cnt = 5'(tbl_count);
    endfunction

    // send one input word; valid is left high so a following word can go back to back
    task automatic send_item(logic [1:0] mode, logic [63:0] hi, logic [63:0] lo,
                             logic lok, logic tok, logic [31:0] now);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= mode;
        in_ch.addr_high   <= hi;
        in_ch.addr_low    <= lo;
        in_ch.length_ok   <= lok;
        in_ch.token_match <= tok;
        in_ch.now_tick    <= now;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_table(mode, hi, lo, lok, tok, now);
    endtask

    // drop valid, let every expected word drain, then give the block time to settle
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (idx)
            CFG_OWN_HIGH:     sh_own_hi   = value;
            CFG_OWN_LOW:      sh_own_lo   = value;
            CFG_TIMEOUT:      sh_timeout  = value[31:0];
            CFG_REV_INTERVAL: sh_interval = value[31:0];
            CFG_LINK_UP:      sh_link     = value[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_all_regs(logic [63:0] own_hi, logic [63:0] own_lo,
                                  logic [31:0] tmo, logic [31:0] ivl, logic up);
        write_reg(CFG_OWN_HIGH, own_hi);
        write_reg(CFG_OWN_LOW, own_lo);
        write_reg(CFG_TIMEOUT, {32'd0, tmo});
        write_reg(CFG_REV_INTERVAL, {32'd0, ivl});
        write_reg(CFG_LINK_UP, {63'd0, up});
    endtask

    // defaults after reset: link down gates discovery and data, not tick or clear
    task automatic test_link_down();
        send_item(MODE_DISC, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 32'd5);
        send_item(MODE_DATA, 64'd0, 64'd0, 1'b0, 1'b0, 32'd6);
        send_item(MODE_TICK, 64'd0, 64'd0, 1'b0, 1'b0, 32'hFFFF_FFFF);
        send_item(MODE_CLEAR, 64'd1, 64'd2, 1'b1, 1'b1, 32'd0);
        wait_drained();
    endtask

    // each discovery verdict, data hit and miss, and a full table
    task automatic test_discovery();
        int k;
        write_all_regs(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 32'd22000, 32'd5200, 1'b1);
        send_item(MODE_DISC, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b0, 1'b1, 32'd10);  // bad length
        send_item(MODE_DISC, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b1, 1'b0, 32'd10);  // own echo
        send_item(MODE_DISC, pool_hi[0], pool_lo[0], 1'b1, 1'b0, 32'd11);          // bad token
        send_item(MODE_DATA, pool_hi[0], pool_lo[0], 1'b1, 1'b1, 32'd12);          // unknown
        for (k = 0; k < TABLE_DEPTH; k++)
            send_item(MODE_DISC, pool_hi[k], pool_lo[k], 1'b1, 1'b1, 32'(20 + k));
        send_item(MODE_DISC, pool_hi[16], pool_lo[16], 1'b1, 1'b1, 32'd40);        // full
        send_item(MODE_DISC, pool_hi[3], pool_lo[3], 1'b1, 1'b1, 32'd41);          // refresh
        send_item(MODE_DATA, pool_hi[15], pool_lo[15], 1'b0, 1'b0, 32'd42);        // accepted
        wait_drained();
    endtask

    // reverse sends, expiry with swap-removal, stamps across the wrap
    task automatic test_aging();
        write_reg(CFG_TIMEOUT, 64'd100);
        write_reg(CFG_REV_INTERVAL, 64'd0);
        send_item(MODE_TICK, 64'd0, 64'd0, 1'b0, 1'b0, 32'd50);    // all reverse
        send_item(MODE_DATA, pool_hi[0], pool_lo[0], 1'b1, 1'b1, 32'd150);
        send_item(MODE_DATA, pool_hi[15], pool_lo[15], 1'b1, 1'b1, 32'd150);
        send_item(MODE_TICK, 64'd0, 64'd0, 1'b0, 1'b0, 32'd141);   // most expire
        send_item(MODE_TICK, 64'd0, 64'd0, 1'b0, 1'b0, 32'd10000); // rest expire
        send_item(MODE_DISC, pool_hi[5], pool_lo[5], 1'b1, 1'b1, 32'hFFFF_FFF0);
        send_item(MODE_TICK, 64'd0, 64'd0, 1'b0, 1'b0, 32'd20);    // wrapped difference
        send_item(MODE_CLEAR, 64'd0, 64'd0, 1'b0, 1'b0, 32'd0);
        wait_drained();
    endtask

    // random words mostly on a small address pool so lookups hit
    task automatic run_random(int count);
        int          k;
        int          pick;
        int          sel;
        logic [1:0]  mode;
        logic [63:0] hi, lo;
        for (k = 0; k < count; k++)
        begin
            if (k % 40 == 0)
                no_gaps = ($urandom_range(0, 2) == 0);
            // hold off once mid-phase until the table has answered everything
            if (k == count / 2)
                wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 50)
                mode = MODE_DISC;
            else if (pick < 70)
                mode = MODE_DATA;
            else if (pick < 96)
                mode = MODE_TICK;
            else
                mode = MODE_CLEAR;
            sel = $urandom_range(0, 29);
            if (sel < 24)
            begin
                hi = pool_hi[sel];
                lo = pool_lo[sel];
            end
            else if (sel < 26)
            begin
                hi = sh_own_hi;
                lo = sh_own_lo;
            end
            else
            begin
                hi = {$urandom, $urandom};
                lo = {$urandom, $urandom};
            end
            clock_now = clock_now + (($urandom_range(0, 9) == 0) ? $urandom
                                                                 : $urandom_range(0, 3000));
            send_item(mode, hi, lo, $urandom_range(0, 9) != 0, $urandom_range(0, 7) != 0,
                      clock_now);
        end
        wait_drained();
    endtask

    task automatic test_random_settings();
        write_all_regs(pool_hi[2], pool_lo[2], 32'd22000, 32'd5200, 1'b1);
        run_random(100);
        write_all_regs({$urandom, $urandom}, {$urandom, $urandom}, 32'hFFFF_FFFF, 32'd0, 1'b1);
        run_random(100);
        write_all_regs(64'd0, 64'd0, 32'd4000, 32'hFFFF_FFFF, 1'b1);
        run_random(100);
        write_all_regs(pool_hi[7], pool_lo[7], $urandom_range(500, 9000),
                       $urandom_range(100, 4000), 1'b1);
        run_random(100);
        write_reg(CFG_TIMEOUT, 64'd0);   // zero timeout expires anything not heard now
        run_random(15);
        write_reg(CFG_LINK_UP, 64'd0);
        run_random(15);
    endtask

    // result side: random stall per word, checks against the oldest expectation
    initial
    begin : result_checker
        int         stall;
        peer_word_t want;
        stall = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: ev %0d count %0d",
                                 out_ch.event_res, out_ch.peer_count);
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (out_ch.event_res !== want.ev || out_ch.peer_addr_high !== want.hi ||
                        out_ch.peer_addr_low !== want.lo || out_ch.peer_count !== want.cnt ||
                        out_ch.last !== want.fin)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d %h_%h %0d %0b got %0d %h_%h %0d %0b",
                                     want.ev, want.hi, want.lo, want.cnt, want.fin,
                                     out_ch.event_res, out_ch.peer_addr_high,
                                     out_ch.peer_addr_low, out_ch.peer_count, out_ch.last);
                    end
                end
                stall = no_gaps ? 0 : $urandom_range(0, 7);
            end
            else if (stall > 0)
                stall--;
            out_ch.ready <= (stall == 0) && rst_n;
        end
    end

    // watchdog on cycles in which nothing moves
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : sequencer
        int k;
        clk = 1'b0;
        rst_n = 1'b0;
        mismatches = 0;
        quiet_cycles = 0;
        no_gaps = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_DISC;
        in_ch.addr_high = 64'd0;
        in_ch.addr_low = 64'd0;
        in_ch.length_ok = 1'b0;
        in_ch.token_match = 1'b0;
        in_ch.now_tick = 32'd0;
        cfg.valid = 1'b0;
        cfg.index = CFG_OWN_HIGH;
        cfg.data = 64'd0;
        // register defaults after reset
        sh_own_hi = 64'd0;
        sh_own_lo = 64'd0;
        sh_timeout = TIMEOUT_RESET;
        sh_interval = REVERSE_RESET;
        sh_link = 1'b0;
        tbl_count = 0;
        clock_now = 32'hFFFF_0000;   // start close to the wrap
        for (k = 0; k < 24; k++)
        begin
            pool_hi[k] = {$urandom, $urandom};
            pool_lo[k] = {$urandom, $urandom};
        end
        pool_hi[23] = 64'hFFFF_FFFF_FFFF_FFFF;
        pool_lo[23] = 64'hFFFF_FFFF_FFFF_FFFF;
        pool_hi[22] = 64'd0;
        pool_lo[22] = 64'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (DRAIN_WAIT) @(posedge clk);

        test_link_down();
        test_discovery();
        test_aging();
        test_random_settings();

        if (mismatches == 0 && pending_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> neighbor_table_with_aging.f
design/nta_pkg.sv
design/nta_in_if.sv
design/nta_out_if.sv
design/nta_cfg_if.sv
design/nta_cfg.sv
design/nta_cell.sv
design/neighbor_table_with_aging.sv
tb/neighbor_table_with_aging_tb.sv
